@@ hw/rtl/saturation_duration_watchdog_core_macros.svh @@
// Assertion macros used by the saturation duration watchdog core.
`ifndef SATURATION_DURATION_WATCHDOG_CORE_MACROS_SVH
`define SATURATION_DURATION_WATCHDOG_CORE_MACROS_SVH

// Checked on every rising edge outside of reset.
`define SDW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define SDW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hw/rtl/sdw_pkg.sv @@
// Types and constants of the saturation duration watchdog.
`timescale 1ns / 1ps
package sdw_pkg;

  localparam int unsigned ChanW    = 2;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned LimitW   = 16;
  localparam int unsigned MagW     = SampleW + 1;
  localparam int unsigned NumLimit = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [TimeW-1:0]  MaxSatTimeRst = 32'd1000000;
  localparam logic [LimitW-1:0] LimitRst      = 16'd32767;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_SAT_TIME = 3'd0,
    CFG_LIMIT_CH0    = 3'd1,
    CFG_LIMIT_CH1    = 3'd2,
    CFG_LIMIT_CH2    = 3'd3,
    CFG_LIMIT_CH3    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [ChanW-1:0]          channel;
    logic signed [SampleW-1:0] sample;
    logic [TimeW-1:0]          time_now;
  } in_item_t;

  typedef struct packed {
    logic enable;
    logic at_limit;
  } out_item_t;

  // One channel's entry in the state memory.
  typedef struct packed {
    logic             below_limit;
    logic [TimeW-1:0] start_time;
  } chan_state_t;

  localparam chan_state_t ChanStateRst = '{below_limit: 1'b1, start_time: '0};

  // What the update logic hands back to the pipeline.
  typedef struct packed {
    logic        wr_en;
    chan_state_t state;
    logic        enable;
    logic        at_limit;
  } upd_t;

endpackage

@@ hw/rtl/sdw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sdw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/sdw_update.sv @@
// Per-sample update of one channel's saturation state and the enable latch.
`timescale 1ns / 1ps
module sdw_update (
  input  sdw_pkg::in_item_t                 item_i,
  input  sdw_pkg::chan_state_t              state_i,
  input  logic                              in_range_i,
  input  logic [sdw_pkg::LimitW-1:0]        limit_i,
  input  logic [sdw_pkg::TimeW-1:0]         max_time_i,
  input  logic                              enable_i,
  output sdw_pkg::upd_t                     upd_o
);
  import sdw_pkg::*;

  logic [MagW-1:0]  mag;
  logic             at_limit;
  chan_state_t      state_new;
  logic [TimeW-1:0] elapsed;
  logic             timeout;

  // Exact magnitude in 17 bits, so the most negative sample maps to 32768.
  assign mag = item_i.sample[SampleW-1]
             ? (MagW'(0) - {1'b1, item_i.sample})
             : {1'b0, item_i.sample};
  assign at_limit = mag >= {1'b0, limit_i};

  always_comb begin
    state_new = state_i;
    if (state_i.below_limit && at_limit) begin
      state_new.below_limit = 1'b0;
      state_new.start_time  = item_i.time_now;
    end else if (!at_limit) begin
      state_new.below_limit = 1'b1;
      state_new.start_time  = item_i.time_now;
    end
  end

  // Elapsed time wraps with the timestamp.
  assign elapsed = item_i.time_now - state_new.start_time;
  assign timeout = elapsed >= max_time_i;

  assign upd_o.wr_en    = in_range_i;
  assign upd_o.state    = state_new;
  assign upd_o.enable   = enable_i & ~(in_range_i & timeout);
  assign upd_o.at_limit = in_range_i & at_limit;

endmodule

@@ hw/rtl/saturation_duration_watchdog_core.sv @@
// Top level of the saturation duration watchdog: state memory pipeline and config registers.
`timescale 1ns / 1ps
// The watchdog takes one controller output sample per transaction, each tagged with a
// channel index and a free-running microsecond timestamp, and returns one result per
// transaction: the latched amplifier enable and whether this sample reached its channel
// limit. A channel that stays at or above its limit for the configured timeout in
// microseconds (measured modulo 2^32) drops the enable, which then stays low until reset.
// A sample for a channel index at or above CHANNELS changes nothing and reports at_limit
// low. The block accepts one transaction every clock cycle. It stalls its input only
// while a result waits on a stalled output and the update stage is occupied. A result
// is presented from the output register: the edge that accepts the sample also reads the
// channel's entry from the state memory, and when the update stage moves on it updates
// the entry, writes it back and loads the output register. Back to back samples on the
// same channel are handled by forwarding the entry just written, so the rate does not
// depend on the channel sequence. The state memory needs no clearing pass after reset;
// a valid bit per channel makes a fresh entry read as its reset value. Configuration is
// written through a plain write port and must only change while the block is idle.
module saturation_duration_watchdog_core #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  sdw_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output sdw_pkg::out_item_t                out_data_o,
  input  logic                              cfg_we_i,
  input  logic [sdw_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [sdw_pkg::CfgDataW-1:0]      cfg_data_i
);
  import sdw_pkg::*;

  `include "saturation_duration_watchdog_core_macros.svh"

  localparam int unsigned AddrW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned StateW = $bits(chan_state_t);

  // Configuration registers.
  logic [TimeW-1:0]  max_time_q;
  logic [LimitW-1:0] limit_q [NumLimit];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_time_q <= MaxSatTimeRst;
      for (int k = 0; k < NumLimit; k++) begin
        limit_q[k] <= LimitRst;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_SAT_TIME: max_time_q <= cfg_data_i;
        CFG_LIMIT_CH0:    limit_q[0] <= cfg_data_i[LimitW-1:0];
        CFG_LIMIT_CH1:    limit_q[1] <= cfg_data_i[LimitW-1:0];
        CFG_LIMIT_CH2:    limit_q[2] <= cfg_data_i[LimitW-1:0];
        CFG_LIMIT_CH3:    limit_q[3] <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake. The update stage moves on when the output register is empty or is being
  // emptied in the same cycle; the input side follows the update stage.
  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_item_q;
  logic      s1_go;
  logic      in_accept;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;

  assign s1_go      = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept || (s1_valid_q && !s1_go);
  assign out_valid_d = s1_go || (out_valid_q && out_stall_i);

  // State memory: one entry per channel holding the below-limit flag and start time.
  logic [AddrW-1:0]  in_addr, s1_addr;
  logic [StateW-1:0] ram_rdata;
  upd_t              upd;
  logic              ram_we;

  assign in_addr = in_data_i.channel[AddrW-1:0];
  assign s1_addr = s1_item_q.channel[AddrW-1:0];
  assign ram_we  = s1_go && upd.wr_en;

  sdw_ram #(
    .Width (StateW),
    .Depth (CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr),
    .wdata_i (upd.state),
    .re_i    (in_accept),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  // The memory returns the old entry when a sample reads the channel that the update
  // stage writes in the same cycle, so that write is captured and forwarded.
  logic        fwd_hit_q;
  chan_state_t fwd_state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (in_accept) begin
      fwd_hit_q <= ram_we && (s1_addr == in_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      fwd_state_q <= upd.state;
      s1_item_q   <= in_data_i;
    end
  end

  // Valid bit per channel; an entry never written reads as its reset value.
  logic [CHANNELS-1:0] written_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (ram_we) begin
      written_q[s1_addr] <= 1'b1;
    end
  end

  logic        s1_in_range;
  chan_state_t s1_state;

  assign s1_in_range = {1'b0, s1_item_q.channel} < (ChanW + 1)'(CHANNELS);

  always_comb begin
    if (fwd_hit_q) begin
      s1_state = fwd_state_q;
    end else if (s1_in_range && written_q[s1_addr]) begin
      s1_state = chan_state_t'(ram_rdata);
    end else begin
      s1_state = ChanStateRst;
    end
  end

  // Enable latch; it only ever falls until reset.
  logic enable_q, enable_d;

  sdw_update u_update (
    .item_i     (s1_item_q),
    .state_i    (s1_state),
    .in_range_i (s1_in_range),
    .limit_i    (limit_q[s1_item_q.channel]),
    .max_time_i (max_time_q),
    .enable_i   (enable_q),
    .upd_o      (upd)
  );

  assign enable_d = s1_go ? upd.enable : enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      enable_q    <= 1'b1;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      enable_q    <= enable_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_q.enable   <= upd.enable;
      out_q.at_limit <= upd.at_limit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Once dropped, the enable stays low.
  `SDW_ASSERT(a_enable_latched, !enable_q |=> !enable_q, "enable rose after a timeout")
  // A pending result always carries the current latch value.
  `SDW_ASSERT(a_out_matches_latch, out_valid_q |-> (out_q.enable == enable_q),
              "pending result disagrees with the enable latch")
  // A sample that leaves the update stage is presented on the next cycle.
  `SDW_ASSERT(a_result_follows, s1_go |=> out_valid_q, "update stage result was lost")
  // The input side only stalls behind an occupied update stage.
  `SDW_ASSERT_ALWAYS(a_stall_cause, in_stall_o |-> s1_valid_q,
                     "input stalled with an empty update stage")

endmodule
